// ----- rtl/sblt_pkg.sv -----
// ----------------------------------------------------------------------------
// sblt_pkg: shared types and constants for the size budget LRU tracker
// Command and status codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package sblt_pkg;

    localparam logic [31:0] BUDGET_RESET = 32'd104857600;

    typedef enum logic [1:0] {
        CMD_ACQUIRE    = 2'd0,
        CMD_INVALIDATE = 2'd1,
        CMD_LOOKUP     = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_HIT       = 3'd5,
        ST_MISS      = 3'd6,
        ST_NONE      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EVICT,
        S_FINAL,
        S_WAIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the incoming beat
        logic evict;      // remove the oldest entry, emit its report
        logic insert;     // store the captured key as most recent
        logic touch;      // make the matched entry most recent
        logic remove;     // remove the matched entry
        logic fin;        // emit the final status result
        t_status status;  // status for the final result
        logic size_zero;  // final out_size is zero
        logic size_held;  // final out_size is the matched entry size
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic too_large;
        logic hit;
        logic need_evict;
        logic out_busy;
    } t_dp_stat;

endpackage

// ----- rtl/sblt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sblt_ctrl: command sequencer
// Steps each command through decide, eviction and final status phases.
// ----------------------------------------------------------------------------
module sblt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sblt_pkg::t_dp_stat i_stat,
    output sblt_pkg::t_dp_cmd  o_cmd
);
    import sblt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.cmd == CMD_UNUSED) begin
                    n_state = S_IDLE;
                end else if (!i_stat.out_busy) begin
                    if (i_stat.cmd == CMD_ACQUIRE && !i_stat.too_large && !i_stat.hit
                        && i_stat.need_evict) begin
                        n_state = S_EVICT;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_EVICT: begin
                if (!i_stat.out_busy && !i_stat.need_evict) begin
                    n_state = S_WAIT;
                end
            end
            S_FINAL: n_state = S_WAIT;
            S_WAIT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_cmd.status = ST_NONE;
        o_ready  = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        unique case (r_state)
            S_DECIDE, S_EVICT: begin
                if (!i_stat.out_busy && i_stat.cmd != CMD_UNUSED) begin
                    priority if (i_stat.cmd == CMD_ACQUIRE && i_stat.too_large) begin
                        o_cmd.fin = 1'b1;
                        o_cmd.status = ST_TOO_LARGE;
                    end else if (i_stat.cmd == CMD_ACQUIRE && i_stat.hit) begin
                        o_cmd.fin = 1'b1;
                        o_cmd.touch = 1'b1;
                        o_cmd.size_held = 1'b1;
                        o_cmd.status = ST_PRESENT;
                    end else if (i_stat.cmd == CMD_ACQUIRE) begin
                        if (i_stat.need_evict) begin
                            o_cmd.evict = 1'b1;
                        end else begin
                            o_cmd.fin = 1'b1;
                            o_cmd.insert = 1'b1;
                            o_cmd.status = ST_STORED;
                        end
                    end else if (i_stat.cmd == CMD_INVALIDATE) begin
                        o_cmd.fin = 1'b1;
                        if (i_stat.hit) begin
                            o_cmd.remove = 1'b1;
                            o_cmd.size_held = 1'b1;
                            o_cmd.status = ST_REMOVED;
                        end else begin
                            o_cmd.size_zero = 1'b1;
                            o_cmd.status = ST_ABSENT;
                        end
                    end else begin
                        o_cmd.fin = 1'b1;
                        if (i_stat.hit) begin
                            o_cmd.touch = 1'b1;
                            o_cmd.size_held = 1'b1;
                            o_cmd.status = ST_HIT;
                        end else begin
                            o_cmd.size_zero = 1'b1;
                            o_cmd.status = ST_MISS;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.evict, o_cmd.insert, o_cmd.remove, o_cmd.touch}))
        else $error("more than one table action");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_evict_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.evict |-> !o_cmd.fin)
        else $error("eviction with final result");
`endif
endmodule

// ----- rtl/sblt_dp.sv -----
// ----------------------------------------------------------------------------
// sblt_dp: slot table, recency ranks, byte count and output register
// ----------------------------------------------------------------------------
module sblt_dp #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_key_tag,
    input  logic [31:0]       i_obj_size,
    input  sblt_pkg::t_dp_cmd  i_dcmd,
    output sblt_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [31:0]       o_out_key,
    output logic [31:0]       o_out_size,
    output logic [2:0]        o_status,
    output logic [31:0]       o_total_bytes,
    output logic              o_last
);
    import sblt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = $clog2(SLOTS + 1);

    logic [31:0] r_key [SLOTS];
    logic [31:0] r_size[SLOTS];
    logic [AW-1:0] r_age[SLOTS];
    logic [SLOTS-1:0] r_vld;
    logic [31:0] r_held, r_budget;
    logic [1:0]  r_cmd;
    logic [31:0] r_ikey, r_isize;
    logic [SLOTS-1:0] r_match;
    logic [AW-1:0] r_cnt;

    logic [SLOTS-1:0] n_match;
    logic [IW-1:0] hit_idx, old_idx, free_idx;
    logic [AW-1:0] hit_age, old_age;
    logic out_busy;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_match[i] = r_vld[i] && (r_key[i] == i_key_tag);
        end
    end

    always_comb begin
        hit_idx = '0;
        old_idx = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) hit_idx = IW'(i);
            if (!r_vld[i]) free_idx = IW'(i);
            if (r_vld[i] && r_age[i] == r_cnt - AW'(1)) old_idx = IW'(i);
        end
        hit_age = r_age[hit_idx];
        old_age = r_age[old_idx];
    end

    assign out_busy = o_valid && !i_ready;

    always_comb begin
        o_stat.cmd = t_cmd'(r_cmd);
        o_stat.too_large = r_isize > r_budget;
        o_stat.hit = |r_match;
        o_stat.need_evict = (r_cnt != '0)
            && ((r_held > r_budget - r_isize) || (r_cnt == AW'(SLOTS)));
        o_stat.out_busy = out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_held <= '0;
            r_budget <= BUDGET_RESET;
            r_cnt <= '0;
            r_cmd <= CMD_UNUSED;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_data != '0) r_budget <= i_cfg_data;
            if (i_dcmd.evict || i_dcmd.fin) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (i_dcmd.load) begin
                r_cmd <= i_cmd;
                r_ikey <= i_key_tag;
                r_isize <= i_obj_size;
                r_match <= n_match;
            end
            if (i_dcmd.evict) begin
                r_vld[old_idx] <= 1'b0;
                r_cnt <= r_cnt - AW'(1);
                r_held <= r_held - ((r_size[old_idx] <= r_held) ? r_size[old_idx] : r_held);
                o_kind <= 1'b0;
                o_out_key <= r_key[old_idx];
                o_out_size <= r_size[old_idx];
                o_status <= ST_STORED;
                o_total_bytes <= r_held
                    - ((r_size[old_idx] <= r_held) ? r_size[old_idx] : r_held);
                o_last <= 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_vld[i] && r_age[i] > old_age) r_age[i] <= r_age[i] - AW'(1);
                end
            end
            if (i_dcmd.remove) begin
                r_vld[hit_idx] <= 1'b0;
                r_cnt <= r_cnt - AW'(1);
                r_held <= r_held - ((r_size[hit_idx] <= r_held) ? r_size[hit_idx] : r_held);
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_vld[i] && r_age[i] > hit_age) r_age[i] <= r_age[i] - AW'(1);
                end
            end
            if (i_dcmd.touch) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_vld[i] && r_age[i] < hit_age) r_age[i] <= r_age[i] + AW'(1);
                end
                r_age[hit_idx] <= '0;
            end
            if (i_dcmd.insert) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_vld[i]) r_age[i] <= r_age[i] + AW'(1);
                end
                r_vld[free_idx] <= 1'b1;
                r_key[free_idx] <= r_ikey;
                r_size[free_idx] <= r_isize;
                r_age[free_idx] <= '0;
                r_cnt <= r_cnt + AW'(1);
                r_held <= r_held + r_isize;
            end
            if (i_dcmd.fin) begin
                o_kind <= 1'b1;
                o_out_key <= r_ikey;
                o_status <= i_dcmd.status;
                o_last <= 1'b1;
                if (i_dcmd.size_zero) begin
                    o_out_size <= '0;
                end else if (i_dcmd.size_held) begin
                    o_out_size <= r_size[hit_idx];
                end else begin
                    o_out_size <= r_isize;
                end
                if (i_dcmd.insert) begin
                    o_total_bytes <= r_held + r_isize;
                end else if (i_dcmd.remove) begin
                    o_total_bytes <= r_held
                        - ((r_size[hit_idx] <= r_held) ? r_size[hit_idx] : r_held);
                end else begin
                    o_total_bytes <= r_held;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == int'(r_cnt))
        else $error("fill count disagrees with valid bits");
    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dcmd.fin || i_dcmd.evict) |-> !out_busy)
        else $error("result issued over a pending one");
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dcmd.insert |-> r_cnt != AW'(SLOTS))
        else $error("insert into full table");
`endif
endmodule

// ----- rtl/size_budget_lru_tracker.sv -----
// Results: the accepting edge loads the command and registers the tag compare;
//   the decide phase then registers the first result beat once no beat is pending.
// Ordering: one command at a time; the next command is accepted only after the
//   final beat of the last one is taken, after all its eviction beats and any
//   receiver stalls (an unused command code gives no beat).
// Reset: synchronous active-low; clears valid bits, byte count and budget to
//   100 MiB. Key, size and rank stores are not cleared.
// ----------------------------------------------------------------------------
// size_budget_lru_tracker: byte-budget LRU cache tracker
// A sequencer drives a slot table with parallel tag compare and recency ranks.
// ----------------------------------------------------------------------------
module size_budget_lru_tracker #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key_tag,
    input  logic [31:0] i_obj_size,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_size,
    output logic [2:0]  o_status,
    output logic [31:0] o_total_bytes,
    output logic        o_last
);
    import sblt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: holds each command until its final beat leaves
    sblt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    // table, byte count and output beat register
    sblt_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(i_cmd), .i_key_tag(i_key_tag), .i_obj_size(i_obj_size),
        .i_dcmd(w_cmd), .o_stat(w_stat), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_out_key(o_out_key), .o_out_size(o_out_size),
        .o_status(o_status), .o_total_bytes(o_total_bytes), .o_last(o_last)
    );
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the size budget LRU tracker
// Drives acquire, invalidate and lookup beats under several byte budgets and
// idle patterns, predicts evictions and final status beats with a software
// slot table, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sblt_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [31:0] size;
        logic [2:0]  status;
        logic [31:0] total;
        logic        last;
    } t_result;

    // Software copy of the slot table; predicts the beats each command causes.
    class lru_scoreboard;
        logic [31:0] key_q [SLOT_COUNT];
        logic [31:0] size_q [SLOT_COUNT];
        bit          live [SLOT_COUNT];
        int unsigned rank [SLOT_COUNT];
        logic [31:0] held;
        logic [31:0] budget;
        t_result     pending [$];
        int          errors;

        function void clear();
            foreach (live[i]) begin
                live[i] = 0;
                rank[i] = 0;
            end
            held = 0;
            budget = BUDGET_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function void set_budget(logic [31:0] v);
            if (v != 0) budget = v;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int i = 0; i < SLOT_COUNT; i++)
                if (live[i] && key_q[i] == k) return i;
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i]) if (live[i]) n++;
            return n;
        endfunction

        function void push(logic kd, logic [31:0] k, logic [31:0] sz, t_status st,
                           logic lst);
            t_result r;
            r.kind = kd; r.key = k; r.size = sz; r.status = st;
            r.total = held; r.last = lst;
            pending.push_back(r);
        endfunction

        function void drop_slot(int s);
            foreach (live[i])
                if (live[i] && rank[i] > rank[s]) rank[i]--;
            live[s] = 0;
            held -= (size_q[s] <= held) ? size_q[s] : held;
        endfunction

        function void promote(int s);
            foreach (live[i])
                if (live[i] && rank[i] < rank[s]) rank[i]++;
            rank[s] = 0;
        endfunction

        function void evict_oldest();
            int b;
            b = -1;
            foreach (live[i])
                if (live[i] && (b < 0 || rank[i] > rank[b])) b = i;
            if (b < 0) return;
            drop_slot(b);
            push(1'b0, key_q[b], size_q[b], ST_STORED, 1'b0);
        endfunction

        // note one accepted command beat
        function void note_command(t_cmd c, logic [31:0] k, logic [31:0] sz);
            int s;
            case (c)
                CMD_ACQUIRE: begin
                    if (sz > budget) begin
                        push(1'b1, k, sz, ST_TOO_LARGE, 1'b1);
                        return;
                    end
                    s = find_slot(k);
                    if (s >= 0) begin
                        promote(s);
                        push(1'b1, k, size_q[s], ST_PRESENT, 1'b1);
                        return;
                    end
                    while (held > budget - sz && live_count() > 0) evict_oldest();
                    if (live_count() >= SLOT_COUNT) evict_oldest();
                    foreach (live[i]) if (live[i]) rank[i]++;
                    for (s = 0; s < SLOT_COUNT && live[s]; s++) ;
                    if (s >= SLOT_COUNT) s = 0;
                    live[s] = 1; key_q[s] = k; size_q[s] = sz; rank[s] = 0;
                    held += sz;
                    push(1'b1, k, sz, ST_STORED, 1'b1);
                end
                CMD_INVALIDATE: begin
                    s = find_slot(k);
                    if (s < 0) push(1'b1, k, 32'd0, ST_ABSENT, 1'b1);
                    else begin
                        drop_slot(s);
                        push(1'b1, k, size_q[s], ST_REMOVED, 1'b1);
                    end
                end
                CMD_LOOKUP: begin
                    s = find_slot(k);
                    if (s < 0) push(1'b1, k, 32'd0, ST_MISS, 1'b1);
                    else begin
                        promote(s);
                        push(1'b1, k, size_q[s], ST_HIT, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result a);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat key=%h status=%0d", $time,
                         a.key, a.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $display("%0t: kind exp %0d act %0d", $time, e.kind, a.kind); errors++;
            end
            if (a.key !== e.key) begin
                $display("%0t: out_key exp %h act %h", $time, e.key, a.key); errors++;
            end
            if (a.size !== e.size) begin
                $display("%0t: out_size exp %h act %h", $time, e.size, a.size); errors++;
            end
            if (a.status !== e.status) begin
                $display("%0t: status exp %0d act %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.total !== e.total) begin
                $display("%0t: total_bytes exp %h act %h", $time, e.total, a.total);
                errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: last exp %0d act %0d", $time, e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_key_tag = '0;
    logic [31:0] i_obj_size = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [31:0] o_out_key;
    logic [31:0] o_out_size;
    logic [2:0]  o_status;
    logic [31:0] o_total_bytes;
    logic        o_last;

    lru_scoreboard cache_model;
    int  send_idle_pct = 0;     // chance in a hundred the sender idles a cycle
    int  recv_stall_pct = 0;    // chance in a hundred the receiver stalls
    int  hold_off_cycles = 0;   // long receiver hold-off, counted down below
    bit  timed_out = 0;
    longint cycle_count = 0;
    logic [31:0] key_pool [8];  // small key set so hits and repeats happen

    size_budget_lru_tracker #(.SLOTS(SLOT_COUNT)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard: give up well past the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            timed_out <= 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every result beat taken at a clock edge.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_valid && i_ready) begin
            r.kind = o_kind; r.key = o_out_key; r.size = o_out_size;
            r.status = o_status; r.total = o_total_bytes; r.last = o_last;
            cache_model.check_result(r);
        end
    end

    // Offer one command beat and hold it until the handshake. Valid stays high
    // afterwards; the next beat or end_burst drops it.
    task automatic send_beat(t_cmd c, logic [31:0] k, logic [31:0] sz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_key_tag <= k;
        i_obj_size <= sz;
        do @(posedge i_clk); while (!o_ready);
        cache_model.note_command(c, k, sz);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted beat has arrived, plus the block's latency.
    task automatic drain();
        while (cache_model.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cache_model.set_budget(v);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) < 8) return key_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    // Random mix leaning on acquire; sizes mostly up to size_span, some zero or fully random.
    task automatic random_burst(int n, logic [31:0] size_span);
        t_cmd c;
        logic [31:0] sz;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) c = CMD_ACQUIRE;
            else if (pick < 70) c = CMD_INVALIDATE;
            else if (pick < 95) c = CMD_LOOKUP;
            else c = CMD_UNUSED;
            case ($urandom_range(19))
                0: sz = $urandom();
                1: sz = 32'd0;
                default: sz = $urandom_range(size_span);
            endcase
            send_beat(c, pick_key(), sz);
        end
        end_burst();
    endtask

    initial begin
        cache_model = new();
        cache_model.clear();
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset budget, extremes, every command, unused code.
        send_beat(CMD_LOOKUP, 32'h0, 32'h0);
        send_beat(CMD_ACQUIRE, 32'h0, 32'h0);
        send_beat(CMD_ACQUIRE, 32'hFFFF_FFFF, BUDGET_RESET);
        send_beat(CMD_ACQUIRE, 32'h1234_5678, BUDGET_RESET + 1);
        send_beat(CMD_ACQUIRE, 32'h0, 32'd5);
        send_beat(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF);
        send_beat(CMD_ACQUIRE, 32'hAAAA_5555, 32'h5555_AAAA);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_INVALIDATE, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_INVALIDATE, 32'hFFFF_FFFF, 32'h0);
        send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        // fill the table past its slot count to force slot evictions
        for (int i = 0; i < 18; i++) send_beat(CMD_ACQUIRE, 32'h100 + i, 32'd1);
        end_burst();
        drain();

        // Budget written while holding entries: next store evicts down to it.
        write_budget(32'd0);
        write_budget(32'd3);
        send_beat(CMD_ACQUIRE, 32'h200, 32'd2);
        send_beat(CMD_ACQUIRE, 32'h201, 32'd3);
        end_burst();
        drain();

        // Small budget, no idling: deep eviction chains.
        write_budget(32'd1000);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_burst(100, 32'd400);
        drain();

        send_idle_pct = 62; recv_stall_pct = 0;
        random_burst(80, 32'd400);
        drain();

        // Minimum budget.
        write_budget(32'd1);
        send_idle_pct = 0; recv_stall_pct = 62;
        random_burst(60, 32'd2);
        drain();

        // Maximum budget; sizes cover the whole range.
        write_budget(32'hFFFF_FFFF);
        send_idle_pct = 38; recv_stall_pct = 38;
        random_burst(80, 32'hFFFF_FFFF);
        drain();

        // Hold the receiver off while the sender keeps offering beats.
        write_budget(BUDGET_RESET);
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 300;
        random_burst(60, 32'd30_000_000);
        drain();

        send_idle_pct = 38; recv_stall_pct = 38;
        random_burst(80, 32'd30_000_000);
        drain();

        if (cache_model.errors == 0 && cache_model.pending.size() == 0 && !timed_out) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/sblt_pkg.sv
rtl/sblt_ctrl.sv
rtl/sblt_dp.sv
rtl/size_budget_lru_tracker.sv
tb/sv/tb_top.sv
